// File: src/pwnd_pkg.sv
// Package for the pulse width nibble deserialiser.
// Holds the bin constants, the class and event codes and the result record.
// Used by every module of the block; it depends on nothing.
package pwnd_pkg;

	localparam int PULSE_W   = 12;
	localparam int CLASS_W   = 5;
	localparam int EVENT_W   = 2;
	localparam int INDEX_W   = 7;
	localparam int BYTE_W    = 8;
	localparam int FILTER_W  = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	localparam int BIN_BASE  = 996;
	localparam int BIN_WIDTH = 56;
	localparam int BIN_COUNT = 18;
	localparam int BIN_TOP   = BIN_BASE + BIN_COUNT * BIN_WIDTH;

	localparam logic [CLASS_W-1:0] CLASS_REPEAT = 5'd16;
	localparam logic [CLASS_W-1:0] CLASS_IDLE   = 5'd17;
	localparam logic [CLASS_W-1:0] CLASS_NONE   = 5'd18;

	localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
	localparam logic [EVENT_W-1:0] EV_BYTE = 2'd1;
	localparam logic [EVENT_W-1:0] EV_IDLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG_LEN  = 1'b1;

	localparam logic [FILTER_W-1:0] FILTER_RESET  = 8'd1;
	localparam logic [INDEX_W-1:0]  MAX_LEN_RESET = 7'd127;

	typedef struct packed {
		logic [CLASS_W-1:0] nibble_class;
		logic [EVENT_W-1:0] event_res;
		logic               store_valid;
		logic [INDEX_W-1:0] store_index;
		logic [BYTE_W-1:0]  store_byte;
		logic               msg_done;
		logic [INDEX_W-1:0] msg_len;
		logic               msg_half_nibble;
		logic               overflow;
	} res_t;

endpackage

// File: src/pwnd_classify.sv
// Comparator bank that sorts a pulse width into one of the eighteen bins.
// Purely combinational; depends on pwnd_pkg for the bin constants.
module pwnd_classify (
	input  logic [pwnd_pkg::PULSE_W-1:0] pulse_width,
	output logic [pwnd_pkg::CLASS_W-1:0] nibble_class
);
	import pwnd_pkg::*;

	always_comb begin
		if (pulse_width < PULSE_W'(BIN_BASE) || pulse_width > PULSE_W'(BIN_TOP)) begin
			nibble_class = CLASS_NONE;
		end else begin
			// A width on a shared edge belongs to the lower bin.
			nibble_class = '0;
			for (int k = 1; k < BIN_COUNT; k++) begin
				if (pulse_width > PULSE_W'(BIN_BASE + k * BIN_WIDTH)) begin
					nibble_class = CLASS_W'(k);
				end
			end
		end
	end

endmodule

// File: src/pwnd_framer.sv
// Symbol filter, byte assembly and message framing state.
// Produces one result record per classified pulse; depends on pwnd_pkg.
module pwnd_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [pwnd_pkg::CLASS_W-1:0]  nibble_class,
	input  logic [pwnd_pkg::FILTER_W-1:0] filter_count,
	input  logic [pwnd_pkg::INDEX_W-1:0]  max_msg_len,
	output pwnd_pkg::res_t                res
);
	import pwnd_pkg::*;

	logic               phase_q, phase_d;
	logic               high_q, high_d;
	logic [CLASS_W-1:0] last_class_q, last_class_d;
	logic [CLASS_W-1:0] last_nibble_q, last_nibble_d;
	logic [FILTER_W-1:0] run_count_q, run_count_d;
	logic [BYTE_W-1:0]  byte_q, byte_d;
	logic [INDEX_W-1:0] msg_count_q, msg_count_d;

	logic                in_range;
	logic                hit;
	logic [FILTER_W-1:0] run_base;
	logic [FILTER_W-1:0] run_next;
	logic [CLASS_W-1:0]  sym;

	always_comb begin
		phase_d       = phase_q;
		high_d        = high_q;
		last_class_d  = last_class_q;
		last_nibble_d = last_nibble_q;
		run_count_d   = run_count_q;
		byte_d        = byte_q;
		msg_count_d   = msg_count_q;

		res              = '0;
		res.nibble_class = nibble_class;

		in_range = (nibble_class != CLASS_NONE);
		run_base = (nibble_class != last_class_q) ? '0 : run_count_q;
		run_next = (run_base != '1) ? run_base + FILTER_W'(1) : run_base;
		hit      = in_range &&
			({1'b0, run_next} == ({1'b0, filter_count} + (FILTER_W + 1)'(1)));
		sym      = (nibble_class == CLASS_REPEAT) ? last_nibble_q : nibble_class;

		if (in_range) begin
			last_class_d = nibble_class;
			run_count_d  = run_next;
		end

		if (hit) begin
			last_nibble_d = sym;
			if (sym == CLASS_IDLE) begin
				res.event_res = EV_IDLE;
				phase_d       = 1'b0;
			end else if (!phase_q) begin
				byte_d  = {sym[3:0], 4'h0};
				high_d  = 1'b1;
				phase_d = 1'b1;
			end else begin
				byte_d        = byte_q | {4'h0, sym[3:0]};
				high_d        = 1'b0;
				phase_d       = 1'b0;
				res.event_res = EV_BYTE;
			end
		end

		case (res.event_res)
			EV_IDLE: begin
				if (high_d) begin
					// A lone high nibble is stored only if the buffer has room.
					if (msg_count_q < max_msg_len) begin
						res.store_valid     = 1'b1;
						res.store_index     = msg_count_q;
						res.store_byte      = byte_d;
						res.msg_done        = 1'b1;
						res.msg_len         = msg_count_q;
						res.msg_half_nibble = 1'b1;
					end
					msg_count_d = '0;
					high_d      = 1'b0;
				end else if (msg_count_q != '0) begin
					res.msg_done = 1'b1;
					res.msg_len  = msg_count_q;
					msg_count_d  = '0;
				end
			end
			EV_BYTE: begin
				if (msg_count_q < max_msg_len) begin
					res.store_valid = 1'b1;
					res.store_index = msg_count_q;
					res.store_byte  = byte_d;
					msg_count_d     = msg_count_q + INDEX_W'(1);
				end else begin
					res.overflow = 1'b1;
					msg_count_d  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= 1'b0;
			high_q        <= 1'b0;
			last_class_q  <= CLASS_NONE;
			last_nibble_q <= CLASS_IDLE;
			run_count_q   <= '0;
			byte_q        <= '0;
			msg_count_q   <= '0;
		end else if (fire) begin
			phase_q       <= phase_d;
			high_q        <= high_d;
			last_class_q  <= last_class_d;
			last_nibble_q <= last_nibble_d;
			run_count_q   <= run_count_d;
			byte_q        <= byte_d;
			msg_count_q   <= msg_count_d;
		end
	end

endmodule

// File: src/pulse_width_nibble_deserializer_top.sv
// Top level of the pulse width nibble deserialiser.
// Depends on pwnd_pkg, pwnd_classify and pwnd_framer.
//
// Usage: each transfer on the input channel (in_valid, in_ready, pulse_width)
// carries one measured pulse width in microseconds. For every input transfer
// exactly one result transfer leaves on the output channel (out_valid,
// out_ready and the result fields), in the same order.
// The pulse is classified by a comparator bank before the input register; the
// filter and framing logic then runs between the input register and the
// output register. One pulse is taken in every cycle while the output is
// being drained. The framing state is updated once per pulse as the pulse
// moves into the output register. When the receiver holds out_ready low, the
// result stays in the output register and the next pulse waits in the input
// register; in_ready is low in every cycle in which both registers are full
// and out_ready is low. Reset clears both stages, the framing state and the
// configuration to filter_count 1 and max_msg_len 127. Configuration is
// written through cfg_wr_en, cfg_index and cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce.
module pulse_width_nibble_deserializer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pwnd_pkg::PULSE_W-1:0]   pulse_width,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pwnd_pkg::CLASS_W-1:0]   nibble_class,
	output logic [pwnd_pkg::EVENT_W-1:0]   event_res,
	output logic                           store_valid,
	output logic [pwnd_pkg::INDEX_W-1:0]   store_index,
	output logic [pwnd_pkg::BYTE_W-1:0]    store_byte,
	output logic                           msg_done,
	output logic [pwnd_pkg::INDEX_W-1:0]   msg_len,
	output logic                           msg_half_nibble,
	output logic                           overflow,
	input  logic                           cfg_wr_en,
	input  logic [pwnd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwnd_pkg::CFG_DAT_W-1:0] cfg_wdata
);
	import pwnd_pkg::*;

	logic [FILTER_W-1:0] filter_count_q;
	logic [INDEX_W-1:0]  max_msg_len_q;

	logic [CLASS_W-1:0] class_in;
	logic [CLASS_W-1:0] class_s1;
	logic               valid_s1;
	res_t               res_comb;
	res_t               res_s2;
	logic               valid_s2;
	logic               adv_s2;
	logic               fire;

	assign adv_s2   = !valid_s2 || out_ready;
	assign fire     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_count_q <= FILTER_RESET;
			max_msg_len_q  <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FILTER_COUNT: filter_count_q <= cfg_wdata;
				REG_MAX_MSG_LEN:  max_msg_len_q  <= cfg_wdata[INDEX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pwnd_classify u_classify (
		.pulse_width  (pulse_width),
		.nibble_class (class_in)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			class_s1 <= class_in;
		end
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	pwnd_framer u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.nibble_class (class_s1),
		.filter_count (filter_count_q),
		.max_msg_len  (max_msg_len_q),
		.res          (res_comb)
	);

	assign out_valid       = valid_s2;
	assign nibble_class    = res_s2.nibble_class;
	assign event_res       = res_s2.event_res;
	assign store_valid     = res_s2.store_valid;
	assign store_index     = res_s2.store_index;
	assign store_byte      = res_s2.store_byte;
	assign msg_done        = res_s2.msg_done;
	assign msg_len         = res_s2.msg_len;
	assign msg_half_nibble = res_s2.msg_half_nibble;
	assign overflow        = res_s2.overflow;

endmodule

// File: src/pwnd_checker.sv
// Port-level checker for the pulse width nibble deserialiser, with its bind.
// Depends on pwnd_pkg and on the port list of the top level.
module pwnd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [pwnd_pkg::CLASS_W-1:0] nibble_class,
	input logic [pwnd_pkg::EVENT_W-1:0] event_res,
	input logic                         store_valid,
	input logic [pwnd_pkg::BYTE_W-1:0]  store_byte,
	input logic                         msg_done,
	input logic                         overflow
);
	import pwnd_pkg::*;

	// A store only ever comes with a completed byte or an accepted idle.
	a_store_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_valid |-> (event_res == EV_BYTE || event_res == EV_IDLE))
		else $error("store without a byte or idle event");

	// An overflow drops the byte, so it never comes with a store.
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> (event_res == EV_BYTE && !store_valid))
		else $error("overflow outside a dropped byte");

	// A message ends only on an accepted idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_done |-> event_res == EV_IDLE)
		else $error("message end without idle");

	// A pulse outside every bin never causes an event.
	a_none_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nibble_class == CLASS_NONE |-> event_res == EV_NONE)
		else $error("event from an out of range pulse");

	// A stalled result transfer stays valid and holds its store byte.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(store_byte))
		else $error("result changed while stalled");

endmodule

bind pulse_width_nibble_deserializer_top pwnd_checker u_pwnd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.nibble_class (nibble_class),
	.event_res    (event_res),
	.store_valid  (store_valid),
	.store_byte   (store_byte),
	.msg_done     (msg_done),
	.overflow     (overflow)
);
